>>> hw/rtl/windowed_time_weighted_average_unit_assert.svh
// ============================================================================
// windowed time-weighted average assertion macros
// clocked assertion helpers included by the top rtl file of the averaging unit
// ============================================================================
`ifndef WINDOWED_TIME_WEIGHTED_AVERAGE_UNIT_ASSERT_SVH
`define WINDOWED_TIME_WEIGHTED_AVERAGE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define WTWA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("wtwa invariant violated");
// consequent must hold in the cycle after the antecedent
`define WTWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wtwa sequence violated");
`else
`define WTWA_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define WTWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/wtwa_pkg.sv
// ============================================================================
// wtwa_pkg
// shared widths, ring entry layout and divider request/response types
// ============================================================================
package wtwa_pkg;

    // default ring depth
    localparam int WTWA_DEPTH_DEF = 64;

    // field widths
    localparam int WTWA_TW = 32;
    localparam int WTWA_VW = 16;
    localparam int WTWA_WW = 16;

    // divider widths
    localparam int WTWA_DIV_NW = 80;
    localparam int WTWA_DIV_DW = 33;

    // configuration register indexes
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_START  = 1'b1;

    // one ring entry
    typedef struct packed {
        logic [WTWA_TW-1:0]        tstamp;
        logic signed [WTWA_VW-1:0] value;
    } t_ring_entry;

    // divider request
    typedef struct packed {
        logic                   start;
        logic [WTWA_DIV_NW-1:0] dividend;
        logic [WTWA_DIV_DW-1:0] divisor;
    } t_div_req;

    // divider response
    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [WTWA_DIV_NW-1:0] quotient;
        logic [WTWA_DIV_DW-1:0] remainder;
    } t_div_rsp;

endpackage

>>> hw/rtl/wtwa_ring_mem.sv
// ============================================================================
// wtwa_ring_mem
// sample ring storage, one write and one registered read port
// ============================================================================
module wtwa_ring_mem
    import wtwa_pkg::*;
#(
    parameter int RING_DEPTH = WTWA_DEPTH_DEF,
    parameter int IW         = $clog2(RING_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  t_ring_entry       i_wr_data,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output t_ring_entry       o_rd_data
);

    t_ring_entry r_mem [RING_DEPTH];
    t_ring_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered; data appears in the cycle after a read enable
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/wtwa_div.sv
// ============================================================================
// wtwa_div
// unsigned restoring divider, one quotient bit per cycle
// ============================================================================
module wtwa_div
    import wtwa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(WTWA_DIV_NW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WTWA_DIV_NW - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [WTWA_DIV_DW-1:0] r_rem;
    logic [WTWA_DIV_NW-1:0] r_quo;
    logic [WTWA_DIV_DW-1:0] r_dvs;

    logic [WTWA_DIV_DW:0]   rem_sh;
    logic [WTWA_DIV_DW:0]   rem_sub;
    logic [WTWA_DIV_DW-1:0] n_rem;
    logic [WTWA_DIV_NW-1:0] n_quo;

    // shift in one dividend bit and trial subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[WTWA_DIV_NW-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        if (rem_sh >= {1'b0, r_dvs}) begin
            n_rem = rem_sub[WTWA_DIV_DW-1:0];
            n_quo = {r_quo[WTWA_DIV_NW-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[WTWA_DIV_DW-1:0];
            n_quo = {r_quo[WTWA_DIV_NW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> hw/rtl/windowed_time_weighted_average_unit.sv
// ============================================================================
// windowed_time_weighted_average_unit
// time-weighted average of timestamped samples over a sliding window held
// in a sample ring, or cumulative since a start tick when the window is zero
// ============================================================================
//
//  channel  | handshake                | word
//  ---------+--------------------------+--------------------------------------
//  sample   | i_valid / o_ready        | i_sample_time, i_sample_value
//  result   | o_valid / i_ready        | o_average, o_average_valid,
//           |                          | o_truncated
//  config   | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
//  one word in flight at a time; o_ready is high only while idle
//  cumulative mode: each word runs at most one division on the 80-step divider
//  window mode: each word runs up to two 80-step divisions, plus one ring read
//  per drop check and per entry held, all on the single read port
//  reset is synchronous and clears control state; the ring needs no clearing
//  a stalled result sits in the output register while the next word is taken
//
module windowed_time_weighted_average_unit
    import wtwa_pkg::*;
#(
    parameter int RING_DEPTH = WTWA_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [WTWA_TW-1:0]        i_sample_time,
    input  logic signed [WTWA_VW-1:0] i_sample_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [31:0]        o_average,
    output logic                      o_average_valid,
    output logic                      o_truncated,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [31:0]               i_cfg_data
);

`include "windowed_time_weighted_average_unit_assert.svh"

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [CW-1:0] TWO   = CW'(2);
    localparam logic [CW-1:0] DEPTH = CW'(RING_DEPTH);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_CUM_ADD   = 15'b000000000000010,
        S_CUM_DIV   = 15'b000000000000100,
        S_CUM_WAIT  = 15'b000000000001000,
        S_DROP_RD   = 15'b000000000010000,
        S_DROP_CHK  = 15'b000000000100000,
        S_RD0       = 15'b000000001000000,
        S_RD1       = 15'b000000010000000,
        S_CHK       = 15'b000000100000000,
        S_FRAC_WAIT = 15'b000001000000000,
        S_FIRST     = 15'b000010000000000,
        S_WALK      = 15'b000100000000000,
        S_AVG       = 15'b001000000000000,
        S_AVG_WAIT  = 15'b010000000000000,
        S_OUT       = 15'b100000000000000
    } t_state;

    // ring index with wrap at the ring depth
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(k);
        if (s >= (CW+1)'(RING_DEPTH)) begin
            s = s - (CW+1)'(RING_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // floor of a signed quotient from its magnitude, saturated to 32 bits
    function automatic logic signed [31:0] floor_sat(input logic [WTWA_DIV_NW-1:0] qm,
                                                     input logic nz,
                                                     input logic neg);
        logic signed [WTWA_DIV_NW+1:0] q;
        q = $signed({2'b00, qm});
        if (neg) begin
            q = -q - $signed({{(WTWA_DIV_NW+1){1'b0}}, nz});
        end
        if (q > $signed((WTWA_DIV_NW+2)'(32'sh7fffffff))) begin
            return 32'sh7fffffff;
        end else if (q < -$signed((WTWA_DIV_NW+2)'(33'sh080000000))) begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // state
    t_state                     r_state, n_state;
    logic [WTWA_WW-1:0]         r_window, n_window;
    logic [WTWA_TW-1:0]         r_start, n_start;
    logic [WTWA_TW-1:0]         r_prev, n_prev;
    logic [IW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic signed [63:0]         r_total, n_total;
    logic signed [31:0]         r_held, n_held;
    logic                       r_held_valid, n_held_valid;
    logic                       r_trunc, n_trunc;
    logic                       r_out_valid, n_out_valid;

    // per-word payload
    logic [WTWA_TW-1:0]         r_t, n_t;
    logic [WTWA_TW-1:0]         r_t0, n_t0;
    logic signed [WTWA_VW-1:0]  r_v0, n_v0;
    logic [WTWA_TW-1:0]         r_pt, n_pt;
    logic signed [WTWA_VW-1:0]  r_pv, n_pv;
    logic signed [WTWA_VW-1:0]  r_v1, n_v1;
    logic [WTWA_WW-1:0]         r_wa, n_wa;
    logic signed [49:0]         r_prod, n_prod;
    logic signed [63:0]         r_first, n_first;
    logic signed [63:0]         r_sum, n_sum;
    logic signed [48:0]         r_inc, n_inc;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_pend, n_pend;
    logic                       r_neg, n_neg;
    logic signed [31:0]         r_out_avg, n_out_avg;
    logic                       r_out_avgv, n_out_avgv;
    logic                       r_out_trunc, n_out_trunc;

    // ring and divider links
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    t_ring_entry                mem_wdata;
    logic                       mem_re;
    logic [IW-1:0]              mem_raddr;
    t_ring_entry                mem_rdata;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    // scratch
    logic                       full;
    logic [IW-1:0]              acc_head;
    logic [CW-1:0]              acc_cnt;
    logic signed [32:0]         dt;
    logic signed [32:0]         el;
    logic signed [64:0]         sum65;
    logic [WTWA_TW-1:0]         age_a;
    logic [WTWA_TW-1:0]         age_b;
    logic [WTWA_TW-1:0]         age_t;
    logic signed [32:0]         dage;
    logic signed [16:0]         vsum;
    logic signed [16:0]         vdiff;
    logic signed [34:0]         vp;
    logic signed [35:0]         vpair;
    logic signed [53:0]         first54;
    logic signed [49:0]         pair_prod;
    logic signed [63:0]         sclamp;
    logic signed [63:0]         stot;
    logic [63:0]                mag;

    wtwa_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IW         (IW)
    ) u_ring (
        .i_clk      (i_clk),
        .i_wr_en    (mem_we),
        .i_wr_addr  (mem_waddr),
        .i_wr_data  (mem_wdata),
        .i_rd_en    (mem_re),
        .i_rd_addr  (mem_raddr),
        .o_rd_data  (mem_rdata)
    );

    wtwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_rsp      (div_rsp)
    );

    // sequencer and datapath
    always_comb begin
        n_state      = r_state;
        n_window     = r_window;
        n_start      = r_start;
        n_prev       = r_prev;
        n_head       = r_head;
        n_count      = r_count;
        n_total      = r_total;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_trunc      = r_trunc;
        n_out_valid  = r_out_valid & ~i_ready;
        n_t          = r_t;
        n_t0         = r_t0;
        n_v0         = r_v0;
        n_pt         = r_pt;
        n_pv         = r_pv;
        n_v1         = r_v1;
        n_wa         = r_wa;
        n_prod       = r_prod;
        n_first      = r_first;
        n_sum        = r_sum;
        n_inc        = r_inc;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_neg        = r_neg;
        n_out_avg    = r_out_avg;
        n_out_avgv   = r_out_avgv;
        n_out_trunc  = r_out_trunc;

        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = slot_of(r_head, ONE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        full     = (r_count >= DEPTH);
        acc_head = full ? slot_of(r_head, ONE) : r_head;
        acc_cnt  = full ? (r_count - ONE) : r_count;
        mem_waddr       = slot_of(acc_head, acc_cnt);
        mem_wdata.tstamp = i_sample_time;
        mem_wdata.value  = i_sample_value;

        dt    = $signed({1'b0, i_sample_time}) - $signed({1'b0, r_prev});
        el    = $signed({1'b0, r_t}) - $signed({1'b0, r_start});
        sum65 = {r_total[63], r_total} + {{16{r_inc[48]}}, r_inc};

        age_a = r_t - r_pt;
        age_b = r_t - mem_rdata.tstamp;
        age_t = r_t - r_t0;
        dage  = $signed({1'b0, age_a}) - $signed({1'b0, age_b});
        vsum  = {r_pv[15], r_pv} + {mem_rdata.value[15], mem_rdata.value};
        vdiff = {r_v1[15], r_v1} - {r_v0[15], r_v0};
        pair_prod = vsum * dage;

        vp      = ($signed({{3{r_v0[15]}}, r_v0, 16'd0}))
                + $signed({{1{r_prod[49]}}, r_prod[49:16]});
        vpair   = {vp[34], vp} + $signed({{4{r_v1[15]}}, r_v1, 16'd0});
        first54 = vpair * $signed({2'b00, r_wa});

        if (r_sum > 64'sh0000400000000000) begin
            sclamp = 64'sh0000400000000000;
        end else if (r_sum < -64'sh0000400000000000) begin
            sclamp = -64'sh0000400000000000;
        end else begin
            sclamp = r_sum;
        end
        stot = r_first + (sclamp <<< 16);
        mag  = stot[63] ? 64'(-stot) : 64'(stot);

        case (r_state)
            // take a word and append it or stage the cumulative increment
            S_IDLE: begin
                if (i_valid) begin
                    n_t    = i_sample_time;
                    n_prev = i_sample_time;
                    if (r_window != '0) begin
                        mem_we  = 1'b1;
                        n_head  = acc_head;
                        n_count = acc_cnt + ONE;
                        n_trunc = full;
                        n_state = ((acc_cnt + ONE) <= TWO) ? S_OUT : S_DROP_RD;
                    end else begin
                        n_trunc = 1'b0;
                        n_inc   = dt * $signed({{17{i_sample_value[15]}}, i_sample_value});
                        n_state = S_CUM_ADD;
                    end
                end
            end
            // saturating accumulate, check elapsed time
            S_CUM_ADD: begin
                if (sum65[64] != sum65[63]) begin
                    n_total = sum65[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
                end else begin
                    n_total = sum65[63:0];
                end
                n_state = (el > 33'sd0) ? S_CUM_DIV : S_OUT;
            end
            S_CUM_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {(r_total[63] ? 64'(-r_total) : 64'(r_total)), 16'd0};
                div_req.divisor  = el;
                n_neg            = r_total[63];
                n_state          = S_CUM_WAIT;
            end
            S_CUM_WAIT: begin
                if (div_rsp.done) begin
                    n_held       = floor_sat(div_rsp.quotient, |div_rsp.remainder, r_neg);
                    n_held_valid = 1'b1;
                    n_state      = S_OUT;
                end
            end
            // drop the oldest while the second oldest is a full window old
            S_DROP_RD: begin
                if (r_count > TWO) begin
                    mem_re  = 1'b1;
                    n_state = S_DROP_CHK;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_DROP_CHK: begin
                if (age_b >= {16'd0, r_window}) begin
                    n_head  = slot_of(r_head, ONE);
                    n_count = r_count - ONE;
                    n_state = S_DROP_RD;
                end else begin
                    n_state = S_RD0;
                end
            end
            // fetch the two oldest entries
            S_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
                n_state   = S_RD1;
            end
            S_RD1: begin
                n_t0    = mem_rdata.tstamp;
                n_v0    = mem_rdata.value;
                mem_re  = 1'b1;
                n_state = S_CHK;
            end
            // interpolation fraction between the two oldest
            S_CHK: begin
                n_pt = mem_rdata.tstamp;
                n_pv = mem_rdata.value;
                n_v1 = mem_rdata.value;
                n_wa = r_window - age_b[WTWA_WW-1:0];
                if (age_t < {16'd0, r_window}) begin
                    n_state = S_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'd0, age_t - {16'd0, r_window}, 32'd0};
                    div_req.divisor  = {1'b0, mem_rdata.tstamp - r_t0};
                    n_state          = S_FRAC_WAIT;
                end
            end
            S_FRAC_WAIT: begin
                if (div_rsp.done) begin
                    n_prod  = vdiff * $signed({1'b0, div_rsp.quotient[31:0]});
                    n_state = S_FIRST;
                end
            end
            // partial trapezoid from the interpolated point
            S_FIRST: begin
                n_first = 64'(first54);
                n_sum   = '0;
                n_idx   = TWO;
                n_pend  = 1'b0;
                n_state = S_WALK;
            end
            // stream the later entries and sum the trapezoids
            S_WALK: begin
                if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_of(r_head, r_idx);
                    n_idx     = r_idx + ONE;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_sum = r_sum + 64'(pair_prod);
                    n_pt  = mem_rdata.tstamp;
                    n_pv  = mem_rdata.value;
                end
                if (!r_pend && (r_idx >= r_count)) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, mag};
                div_req.divisor  = {16'd0, r_window, 1'b0};
                n_neg            = stot[63];
                n_state          = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    n_held       = floor_sat(div_rsp.quotient, |div_rsp.remainder, r_neg);
                    n_held_valid = 1'b1;
                    n_state      = S_OUT;
                end
            end
            // hand the word to the output register
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_held;
                    n_out_avgv  = r_held_valid;
                    n_out_trunc = r_trunc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW: begin
                    n_window = i_cfg_data[WTWA_WW-1:0];
                end
                CFG_START: begin
                    n_start = i_cfg_data;
                    n_prev  = i_cfg_data;
                end
                default: begin
                    n_window = r_window;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= '0;
            r_start      <= '0;
            r_prev       <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_total      <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_trunc      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_window     <= n_window;
            r_start      <= n_start;
            r_prev       <= n_prev;
            r_head       <= n_head;
            r_count      <= n_count;
            r_total      <= n_total;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_trunc      <= n_trunc;
            r_out_valid  <= n_out_valid;
            r_pend       <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_t0        <= n_t0;
        r_v0        <= n_v0;
        r_pt        <= n_pt;
        r_pv        <= n_pv;
        r_v1        <= n_v1;
        r_wa        <= n_wa;
        r_prod      <= n_prod;
        r_first     <= n_first;
        r_sum       <= n_sum;
        r_inc       <= n_inc;
        r_idx       <= n_idx;
        r_neg       <= n_neg;
        r_out_avg   <= n_out_avg;
        r_out_avgv  <= n_out_avgv;
        r_out_trunc <= n_out_trunc;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_average       = r_out_avg;
    assign o_average_valid = r_out_avgv;
    assign o_truncated     = r_out_trunc;

    // checks
    `WTWA_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH)
    `WTWA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `WTWA_ASSERT_ALWAYS(a_div_idle_start, i_clk, i_rst_n, !(div_req.start && div_rsp.busy))

endmodule

>>> tb/sv/windowed_time_weighted_average_unit_tb.sv
// ============================================================================
// windowed_time_weighted_average_unit_tb
// drives timestamped sample words into the averaging unit, predicts every
// result word with a behavioral copy of the window and cumulative averaging,
// and compares the result channel field by field in arrival order
// ============================================================================
module windowed_time_weighted_average_unit_tb;
    import wtwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH      = 64;
    localparam int  CYCLE_CAP  = 3_000_000;
    localparam int  PHASES     = 12;
    localparam int  PHASE_LEN  = 110;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    localparam longint SUM_CAP = 64'sh0000_4000_0000_0000;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_e;

    // one directed step: a register write or a sample word
    typedef struct packed {
        row_kind_e          kind;
        bit                 typed;
        logic               idx;
        logic [31:0]        arg;
        logic signed [15:0] val;
        logic [31:0]        e_avg;
        bit                 e_av;
        bit                 e_tr;
    } row_t;

    typedef struct packed {
        logic signed [31:0] avg;
        bit                 av;
        bit                 tr;
    } avg_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [31:0]        i_sample_time = '0;
    logic signed [15:0] i_sample_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_average;
    logic               o_average_valid;
    logic               o_truncated;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_WINDOW;
    logic [31:0]        i_cfg_data = '0;

    windowed_time_weighted_average_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_average      (o_average),
        .o_average_valid(o_average_valid),
        .o_truncated    (o_truncated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        win_len;
    logic [31:0]        cum_start;
    logic [31:0]        hist_time [DEPTH];
    longint             hist_value [DEPTH];
    int                 hist_head;
    int                 hist_count;
    logic [31:0]        last_time;
    longint             cum_total;
    logic signed [31:0] hold_avg;
    bit                 hold_valid;

    avg_word_t          pending_results [$];
    int                 errs = 0;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    int                 sink_stall = 0;

    row_t directed_plan [26] = '{
        // cumulative from tick zero
        '{ROW_WORD, 1, CFG_WINDOW, 32'd0,  16'sd0,      32'h0000_0000, 0, 0},
        '{ROW_WORD, 1, CFG_WINDOW, 32'd10, 16'sd32767,  32'h7FFF_0000, 1, 0},
        '{ROW_WORD, 1, CFG_WINDOW, 32'd20, -16'sd32768, 32'hFFFF_8000, 1, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd15, 16'sd100,    '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'hFFFF_FFFF, 16'sd32767, '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd0,  -16'sd1,     '0, 0, 0},
        // samples before, at and after the start tick
        '{ROW_CFG,  0, CFG_START,  32'd1000, 16'sd0,    '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd500,  16'sd5,    '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd1000, 16'sd7,    '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd1064, -16'sd3,   '0, 0, 0},
        // widest window
        '{ROW_CFG,  0, CFG_WINDOW, 32'd65535, 16'sd0,   '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd0,      16'sd100,    '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd40000,  -16'sd32768, '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd70000,  16'sd32767,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd200000, 16'sd1,      '0, 0, 0},
        // one-tick window, equal and backward times
        '{ROW_CFG,  0, CFG_WINDOW, 32'd1, 16'sd0,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd1, 16'sd1,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd1, 16'sd2,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd2, 16'sd3,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd3, -16'sd4, '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd3, 16'sd5,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd2, -16'sd7, '0, 0, 0},
        // back to cumulative with the start at the top of the range
        '{ROW_CFG,  0, CFG_WINDOW, 32'd0, 16'sd0,  '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'hFFFF_FFFF, -16'sd32768, '0, 0, 0},
        '{ROW_CFG,  0, CFG_START,  32'hFFFF_FFFF, 16'sd0, '0, 0, 0},
        '{ROW_WORD, 0, CFG_WINDOW, 32'd0, 16'sd1,  '0, 0, 0}
    };

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // age of ring entry k relative to the newest tick, modulo 2^32
    function automatic longint entry_age(input int k, input logic [31:0] t);
        logic [31:0] diff;
        diff = t - hist_time[(hist_head + k) % DEPTH];
        return longint'({32'd0, diff});
    endfunction

    function automatic void drop_oldest();
        hist_head  = (hist_head + 1) % DEPTH;
        hist_count = hist_count - 1;
    endfunction

    // sliding window: interpolate the window edge, trapezoids up to newest
    function automatic bit window_average(input logic [31:0] t, input longint v,
                                          output logic signed [31:0] avg,
                                          output bit trunc);
        longint w, t_age, a1, frac, v0, v1, vp, first, sum2, s;
        longint unsigned num;
        int k;
        w     = longint'({16'd0, win_len[15:0]});
        trunc = 1'b0;
        avg   = '0;
        sum2  = 0;
        if (hist_count >= DEPTH) begin
            drop_oldest();
            trunc = 1'b1;
        end
        hist_time[(hist_head + hist_count) % DEPTH]  = t;
        hist_value[(hist_head + hist_count) % DEPTH] = v;
        hist_count = hist_count + 1;
        if (hist_count <= 2) return 1'b0;
        while (hist_count > 2 && entry_age(1, t) >= w) drop_oldest();
        t_age = entry_age(0, t);
        if (t_age < w) return 1'b0;
        a1    = entry_age(1, t);
        num   = longint'(t_age - w);
        num   = num << 32;
        num   = num / longint'(t_age - a1);
        frac  = longint'(num);
        v0    = hist_value[hist_head % DEPTH];
        v1    = hist_value[(hist_head + 1) % DEPTH];
        vp    = v0 * 65536 + floor_div((v1 - v0) * frac, 65536);
        first = (vp + v1 * 65536) * (w - a1);
        for (k = 1; k + 1 < hist_count; k++) begin
            sum2 += (hist_value[(hist_head + k) % DEPTH] +
                     hist_value[(hist_head + k + 1) % DEPTH]) *
                    (entry_age(k, t) - entry_age(k + 1, t));
        end
        if (sum2 > SUM_CAP) sum2 = SUM_CAP;
        if (sum2 < -SUM_CAP) sum2 = -SUM_CAP;
        s   = first + sum2 * 65536;
        avg = clip32(floor_div(s, 2 * w));
        return 1'b1;
    endfunction

    // cumulative: saturating sum of value times elapsed ticks
    function automatic bit cumulative_average(input logic [31:0] t, input longint v,
                                              output logic signed [31:0] avg);
        longint dt, inc, e, q, r;
        avg = '0;
        dt  = longint'({32'd0, t}) - longint'({32'd0, last_time});
        inc = dt * v;
        if (inc > 0 && cum_total > I64_MAX - inc) cum_total = I64_MAX;
        else if (inc < 0 && cum_total < I64_MIN - inc) cum_total = I64_MIN;
        else cum_total = cum_total + inc;
        e = longint'({32'd0, t}) - longint'({32'd0, cum_start});
        if (e <= 0) return 1'b0;
        q = floor_div(cum_total, e);
        r = cum_total - q * e;
        if (q >= 32768) avg = 32'sh7FFF_FFFF;
        else if (q < -32768) avg = 32'sh8000_0000;
        else avg = clip32(q * 65536 + floor_div(r * 65536, e));
        return 1'b1;
    endfunction

    function automatic avg_word_t predict_average(input logic [31:0] t,
                                                  input logic signed [15:0] v);
        avg_word_t res;
        logic signed [31:0] avg;
        bit trunc, fresh;
        trunc = 1'b0;
        if (win_len[15:0] != 0) fresh = window_average(t, longint'(v), avg, trunc);
        else fresh = cumulative_average(t, longint'(v), avg);
        if (fresh) begin
            hold_avg   = avg;
            hold_valid = 1'b1;
        end
        last_time = t;
        res.avg = hold_avg;
        res.av  = hold_valid;
        res.tr  = trunc;
        return res;
    endfunction

    // one register write, mirrored into the predictor at the write edge
    task automatic write_register(input logic idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WINDOW) begin
            win_len = {16'd0, data[15:0]};
        end else begin
            cum_start = data;
            last_time = data;
        end
    endtask

    // hold off until every result word is back and the unit is idle
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || !o_ready);
    endtask

    // offer one sample word and record its expected result once taken
    task automatic send_word(input logic [31:0] t, input logic signed [15:0] v,
                             input bit typed, input avg_word_t typed_res);
        avg_word_t res;
        i_valid        <= 1'b1;
        i_sample_time  <= t;
        i_sample_value <= v;
        do @(posedge i_clk); while (!o_ready);
        res = predict_average(t, v);
        if (typed) res = typed_res;
        pending_results.push_back(res);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // result sink with random stall bursts
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            i_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 3);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    avg_word_t got_exp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word average=%h", o_average);
                errs++;
            end else begin
                got_exp = pending_results.pop_front();
                if (o_average !== got_exp.avg) begin
                    $error("average expected %h got %h", got_exp.avg, o_average);
                    errs++;
                end
                if (o_average_valid !== got_exp.av) begin
                    $error("average_valid expected %0d got %0d", got_exp.av,
                           o_average_valid);
                    errs++;
                end
                if (o_truncated !== got_exp.tr) begin
                    $error("truncated expected %0d got %0d", got_exp.tr, o_truncated);
                    errs++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL windowed_time_weighted_average_unit");
            $finish;
        end
    end

    initial begin
        int            p, n, r, i;
        logic [31:0]   w, t;
        logic signed [15:0] v;
        avg_word_t     typed_res;

        win_len    = '0;
        cum_start  = '0;
        hist_head  = 0;
        hist_count = 0;
        last_time  = '0;
        cum_total  = 0;
        hold_avg   = '0;
        hold_valid = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (i = 0; i < 26; i++) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_register(directed_plan[i].idx, directed_plan[i].arg);
            end else begin
                typed_res.avg = directed_plan[i].e_avg;
                typed_res.av  = directed_plan[i].e_av;
                typed_res.tr  = directed_plan[i].e_tr;
                send_word(directed_plan[i].arg, directed_plan[i].val,
                          directed_plan[i].typed, typed_res);
            end
        end

        // random phases, each with its own window and sometimes a new start setting
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            calm = (p >= PHASES - 2);
            case (p % 6)
                0: w = 32'd0;
                1: w = 32'd65535;
                2: w = 32'd1;
                3: w = $urandom_range(2, 300);
                4: w = $urandom_range(1, 65535);
                default: w = $urandom_range(16, 2000);
            endcase
            write_register(CFG_WINDOW, w);
            r = $urandom_range(0, 3);
            if (r == 0) t = 32'd0;
            else if (r == 1) t = 32'hFFFF_FFF0;
            else t = $urandom;
            if ($urandom_range(0, 1) == 0 || w == 0) write_register(CFG_START, t);
            for (n = 0; n < PHASE_LEN; n++) begin
                if (p == 7 && n == PHASE_LEN / 2) wait_idle();
                r = $urandom_range(0, 99);
                if (r < 4) t = $urandom;
                else if (r < 8) t = t;
                else if (r < 18) t = t + $urandom_range(0, (w == 0) ? 100000 : 2 * w);
                else t = t + $urandom_range(0, (w == 0) ? 4000 : ((w / 24) + 1));
                r = $urandom_range(0, 9);
                if (r == 0) v = 16'sh7FFF;
                else if (r == 1) v = 16'sh8000;
                else v = $urandom;
                send_word(t, v, 1'b0, typed_res);
            end
        end

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (errs == 0)
            $display("PASS windowed_time_weighted_average_unit");
        else
            $display("FAIL windowed_time_weighted_average_unit");
        $finish;
    end

endmodule
